// ===== hdl/fwqt_pkg.sv =====
// shared types and constants for the futex wait queue table
package fwqt_pkg;
   localparam int ENTRIES_DEF = 32;
   localparam int WAITERS_DEF = 16;
   localparam int ADDR_W = 48;
   localparam int ID_W = 16;

   localparam logic [6:0] OP_WAIT        = 7'd0;
   localparam logic [6:0] OP_WAKE        = 7'd1;
   localparam logic [6:0] OP_REQUEUE     = 7'd3;
   localparam logic [6:0] OP_CMP_REQUEUE = 7'd4;
   localparam logic [6:0] OP_WAKE_OP     = 7'd5;
   localparam logic [6:0] OP_WAIT_BITSET = 7'd9;
   localparam logic [6:0] OP_WAKE_BITSET = 7'd10;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_AGAIN = 2'd1;
   localparam logic [1:0] ST_NOMEM = 2'd2;
   localparam logic [1:0] ST_NOSYS = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word
      logic scan_clr;   // restart entry scan
      logic scan_step;  // examine one entry
      logic cnt_rd;     // read count of found entry
      logic push;       // append waiter
      logic wake_set;   // latch wake amount
      logic mv_step;    // move one waiter id
      logic wake_done;  // update count and valid
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_wait;
      logic is_wake;
      logic is_bitset;
      logic is_noop;
      logic match;
      logic scan_end;
      logic found;
      logic has_free;
      logic mv_end;
   } stat_type;
endpackage

// ===== hdl/fwqt_datapath.sv =====
// entry table, waiter memory and scan/shift counters
module fwqt_datapath #(
   parameter int ENTRIES = fwqt_pkg::ENTRIES_DEF,
   parameter int WAITERS = fwqt_pkg::WAITERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fwqt_pkg::cmd_type         cmd,
   output fwqt_pkg::stat_type        stat,
   input  logic [6:0]                req_type,
   input  logic [fwqt_pkg::ADDR_W-1:0] req_futex_address,
   input  logic signed [31:0]        req_word_value,
   input  logic signed [31:0]        req_arg_value,
   input  logic [fwqt_pkg::ID_W-1:0] req_requester_id,
   output logic [4:0]                woken
);
   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int CW = $clog2(WAITERS + 1);
   localparam int SW = $clog2(ENTRIES + 2);

   logic [6:0] op_ff;
   logic [fwqt_pkg::ADDR_W-1:0] addr_ff;
   logic signed [31:0] arg_ff;
   logic match_ff;
   logic [fwqt_pkg::ID_W-1:0] id_ff;

   logic [ENTRIES-1:0] valid_ff;
   logic [fwqt_pkg::ADDR_W-1:0] addr_mem [ENTRIES];
   logic [CW-1:0] cnt_mem [ENTRIES];
   logic [fwqt_pkg::ID_W-1:0] id_mem [ENTRIES * (1 << WW)];

   logic [SW-1:0] scan_ff;
   logic found_ff, free_ok_ff;
   logic [EW-1:0] hit_ff, free_ff;
   logic [CW-1:0] cnt_ff, take_ff, mv_ff;
   logic [fwqt_pkg::ADDR_W-1:0] scan_addr_ff;
   logic scan_vld_ff;
   logic [EW-1:0] sel;
   logic [EW+WW-1:0] base;
   logic [fwqt_pkg::ID_W-1:0] mv_data_ff;
   logic mv_pend_ff;
   logic [EW+WW-1:0] mv_wr_ff;
   logic [CW-1:0] take_in;
   logic [31:0] arg_clip;

   assign sel = found_ff ? hit_ff : free_ff;
   assign base = {sel, {WW{1'b0}}};
   assign arg_clip = (arg_ff[31] || arg_ff == 0) ? 32'd0 : arg_ff;
   assign take_in = (arg_clip > 32'(cnt_ff)) ? cnt_ff : CW'(arg_clip);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_type;
         addr_ff <= req_futex_address;
         arg_ff <= req_arg_value;
         match_ff <= (req_word_value == req_arg_value);
         id_ff <= req_requester_id;
      end
   end

   // entry scan: one entry a cycle, registered read then compare
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         scan_ff <= '0;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_ff < SW'(ENTRIES)) begin
            scan_addr_ff <= addr_mem[scan_ff[EW-1:0]];
            scan_vld_ff <= valid_ff[scan_ff[EW-1:0]];
            if (!valid_ff[scan_ff[EW-1:0]] && !free_ok_ff) begin
               free_ok_ff <= 1'b1;
               free_ff <= scan_ff[EW-1:0];
            end
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (!reset && !cmd.scan_clr && cmd.scan_step && scan_ff != '0 && !found_ff &&
          scan_vld_ff && scan_addr_ff == addr_ff) begin
         found_ff <= 1'b1;
         hit_ff <= scan_ff[EW-1:0] - 1'b1;
      end
   end

   // count and waiter moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mv_pend_ff <= 1'b0;
      end else begin
         if (cmd.cnt_rd) cnt_ff <= found_ff ? cnt_mem[hit_ff] : '0;
         if (cmd.push) begin
            if (!found_ff) begin
               valid_ff[free_ff] <= 1'b1;
               addr_mem[free_ff] <= addr_ff;
            end
            if (cnt_ff < CW'(WAITERS)) begin
               id_mem[base + (EW+WW)'(cnt_ff)] <= id_ff;
               cnt_mem[sel] <= cnt_ff + 1'b1;
            end
         end
         if (cmd.wake_set) begin
            take_ff <= take_in;
            mv_ff <= take_in;
         end
         mv_pend_ff <= cmd.mv_step && (mv_ff < cnt_ff);
         if (cmd.mv_step && mv_ff < cnt_ff) begin
            mv_data_ff <= id_mem[base + (EW+WW)'(mv_ff)];
            mv_wr_ff <= base + (EW+WW)'(mv_ff - take_ff);
            mv_ff <= mv_ff + 1'b1;
         end
         if (mv_pend_ff) id_mem[mv_wr_ff] <= mv_data_ff;
         if (cmd.wake_done && found_ff) begin
            cnt_mem[hit_ff] <= cnt_ff - take_ff;
            if (cnt_ff == take_ff) valid_ff[hit_ff] <= 1'b0;
         end
      end
   end

   assign woken = found_ff ? 5'(take_ff) : 5'd0;

   always_comb begin
      stat.is_wait = (op_ff == fwqt_pkg::OP_WAIT);
      stat.is_wake = (op_ff == fwqt_pkg::OP_WAKE);
      stat.is_bitset = (op_ff == fwqt_pkg::OP_WAIT_BITSET);
      stat.is_noop = (op_ff == fwqt_pkg::OP_REQUEUE) || (op_ff == fwqt_pkg::OP_CMP_REQUEUE) ||
                     (op_ff == fwqt_pkg::OP_WAKE_OP) || (op_ff == fwqt_pkg::OP_WAKE_BITSET);
      stat.match = match_ff;
      stat.scan_end = (scan_ff == SW'(ENTRIES + 1));
      stat.found = found_ff;
      stat.has_free = free_ok_ff;
      stat.mv_end = (mv_ff >= cnt_ff) && !mv_pend_ff;
   end

   // checks
   a_take_le_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.mv_step |-> take_ff <= cnt_ff) else $error("wake amount above count");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= SW'(ENTRIES + 1)) else $error("scan ran past table");
   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> found_ff || free_ok_ff) else $error("push without entry");
endmodule

// ===== hdl/fwqt_ctrl.sv =====
// request sequencer for the futex wait queue table
module fwqt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_woken_count,
   input  logic [4:0]          woken,
   output fwqt_pkg::cmd_type   cmd,
   input  fwqt_pkg::stat_type  stat
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_CNT  = 3'd3;
   localparam logic [2:0] S_ACT  = 3'd4;
   localparam logic [2:0] S_MOVE = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_RSP  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic [4:0] woken_ff, woken_in;
   logic rsp_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_status = status_ff;
   assign rsp_woken_count = woken_ff;

   // next state and commands
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      status_in = status_ff;
      woken_in = woken_ff;
      rsp_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.scan_clr = 1'b1;
            woken_in = 5'd0;
            status_in = fwqt_pkg::ST_OK;
            if (stat.is_wait) begin
               if (stat.match) state_in = S_SCAN;
               else begin
                  status_in = fwqt_pkg::ST_AGAIN;
                  state_in = S_RSP;
               end
            end else if (stat.is_wake) state_in = S_SCAN;
            else begin
               if (stat.is_bitset && !stat.match) status_in = fwqt_pkg::ST_AGAIN;
               else if (!stat.is_bitset && !stat.is_noop) status_in = fwqt_pkg::ST_NOSYS;
               state_in = S_RSP;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               cmd.scan_step = 1'b0;
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            cmd.cnt_rd = 1'b1;
            if (stat.is_wait && !stat.found && !stat.has_free) begin
               status_in = fwqt_pkg::ST_NOMEM;
               state_in = S_RSP;
            end else state_in = S_ACT;
         end
         S_ACT: begin
            if (stat.is_wait) begin
               cmd.push = 1'b1;
               state_in = S_RSP;
            end else if (stat.found) begin
               cmd.wake_set = 1'b1;
               state_in = S_MOVE;
            end else state_in = S_RSP;
         end
         S_MOVE: begin
            cmd.mv_step = 1'b1;
            if (stat.mv_end) begin
               cmd.mv_step = 1'b0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.wake_done = 1'b1;
            woken_in = woken;
            state_in = S_RSP;
         end
         S_RSP: begin
            rsp_in = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      status_ff <= status_in;
      woken_ff <= woken_in;
   end

   // checks
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_in && rsp_stall |=> rsp_valid && $stable(rsp_status)) else $error("word dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.wake_set, cmd.mv_step, cmd.wake_done}))
      else $error("conflicting commands");
   a_nomem_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fwqt_pkg::ST_NOMEM |-> stat.is_wait)
      else $error("nomem on non-wait");
endmodule

// ===== hdl/futex_wait_queue_table_top.sv =====
// Futex wait queue table top level. One request word in, one response word out; a new
// request is taken only once the previous response has gone. A wait, or a wake that finds
// no entry, passes through decode, a lookup scan with a registered read, a count read and
// an update before it offers its response; a wait that finds the table full skips the
// update. A wake that finds its entry adds a shift phase and then a final update (waiter
// ids move one per cycle). Other codes offer the response straight after decode. A
// stalled response is held until it is taken. No clearing pass.
module futex_wait_queue_table_top #(
   parameter int ENTRIES = fwqt_pkg::ENTRIES_DEF,
   parameter int WAITERS = fwqt_pkg::WAITERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [6:0]                  req_type,
   input  logic [fwqt_pkg::ADDR_W-1:0] req_futex_address,
   input  logic signed [31:0]          req_word_value,
   input  logic signed [31:0]          req_arg_value,
   input  logic [fwqt_pkg::ID_W-1:0]   req_requester_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [4:0]                  rsp_woken_count
);
   fwqt_pkg::cmd_type cmd;
   fwqt_pkg::stat_type stat;
   logic [4:0] woken;

   // sequencer
   fwqt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_woken_count(rsp_woken_count), .woken(woken), .cmd(cmd), .stat(stat)
   );

   // table and queues
   fwqt_datapath #(.ENTRIES(ENTRIES), .WAITERS(WAITERS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_type(req_type),
      .req_futex_address(req_futex_address), .req_word_value(req_word_value),
      .req_arg_value(req_arg_value), .req_requester_id(req_requester_id), .woken(woken)
   );
endmodule

// ===== dv/futex_wait_queue_table_top_tb.sv =====
// testbench for the futex wait queue table: random and directed requests against a predictor
module futex_wait_queue_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NENT = 32;
   localparam int NWAIT = 16;
   localparam int RAND_ITEMS = 1080;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [6:0]                  op;
      logic [fwqt_pkg::ADDR_W-1:0] addr;
      logic signed [31:0]          word;
      logic signed [31:0]          arg;
      logic [fwqt_pkg::ID_W-1:0]   who;
   } futex_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] woken;
   } futex_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [6:0] req_type = '0;
   logic [fwqt_pkg::ADDR_W-1:0] req_futex_address = '0;
   logic signed [31:0] req_word_value = '0;
   logic signed [31:0] req_arg_value = '0;
   logic [fwqt_pkg::ID_W-1:0] req_requester_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [4:0] rsp_woken_count;

   futex_wait_queue_table_top uut (.*);

   // predictor state
   logic                        tbl_valid [NENT];
   logic [fwqt_pkg::ADDR_W-1:0] tbl_addr [NENT];
   int                          tbl_count [NENT];
   logic [fwqt_pkg::ID_W-1:0]   tbl_ids [NENT][NWAIT];

   futex_req_type pending_reqs[$];
   futex_rsp_type expected_rsps[$];
   int mismatches = 0;
   int rsp_seen = 0;
   int cycle_count = 0;
   int wakes_sent = 0;
   int nomem_seen = 0;
   bit calm = 1'b0;
   logic [fwqt_pkg::ADDR_W-1:0] addr_pool [8];
   int drv_gap = 0;
   int rsp_gap = 0;
   logic req_stall_q = 1'b1;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic futex_rsp_type predict_futex(futex_req_type r);
      futex_rsp_type o;
      int e;
      int take;
      o.status = fwqt_pkg::ST_OK;
      o.woken = '0;
      e = -1;
      case (r.op)
         fwqt_pkg::OP_WAIT: begin
            if (r.word != r.arg) begin
               o.status = fwqt_pkg::ST_AGAIN;
            end else begin
               for (int i = NENT - 1; i >= 0; i--)
                  if (tbl_valid[i] && tbl_addr[i] == r.addr) e = i;
               if (e < 0) begin
                  for (int i = NENT - 1; i >= 0; i--)
                     if (!tbl_valid[i]) e = i;
                  if (e >= 0) begin
                     tbl_valid[e] = 1'b1;
                     tbl_addr[e] = r.addr;
                     tbl_count[e] = 0;
                  end
               end
               if (e < 0) begin
                  o.status = fwqt_pkg::ST_NOMEM;
               end else if (tbl_count[e] < NWAIT) begin
                  tbl_ids[e][tbl_count[e]] = r.who;
                  tbl_count[e]++;
               end
            end
         end
         fwqt_pkg::OP_WAKE: begin
            for (int i = NENT - 1; i >= 0; i--)
               if (tbl_valid[i] && tbl_addr[i] == r.addr) e = i;
            if (e >= 0) begin
               take = (r.arg <= 0) ? 0 : ((r.arg > tbl_count[e]) ? tbl_count[e] : int'(r.arg));
               for (int i = take; i < tbl_count[e]; i++) tbl_ids[e][i - take] = tbl_ids[e][i];
               tbl_count[e] -= take;
               if (tbl_count[e] == 0) tbl_valid[e] = 1'b0;
               o.woken = take[4:0];
            end
         end
         fwqt_pkg::OP_WAIT_BITSET: if (r.word != r.arg) o.status = fwqt_pkg::ST_AGAIN;
         fwqt_pkg::OP_REQUEUE, fwqt_pkg::OP_CMP_REQUEUE, fwqt_pkg::OP_WAKE_OP,
         fwqt_pkg::OP_WAKE_BITSET: ;
         default: o.status = fwqt_pkg::ST_NOSYS;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0d expected %0d", rsp_seen, what, got, want);
      mismatches++;
   endtask

   function automatic futex_req_type make_req(logic [6:0] op, logic [fwqt_pkg::ADDR_W-1:0] a,
                                             logic signed [31:0] w, logic signed [31:0] g,
                                             logic [fwqt_pkg::ID_W-1:0] id);
      futex_req_type r;
      r.op = op; r.addr = a; r.word = w; r.arg = g; r.who = id;
      return r;
   endfunction

   // random request, mostly waits and wakes on a small address pool
   function automatic futex_req_type rand_req();
      futex_req_type r;
      int pick;
      logic signed [31:0] v;
      pick = $urandom_range(99);
      v = $urandom;
      r.who = 16'($urandom);
      r.addr = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                         : addr_pool[$urandom_range(7)];
      r.word = v;
      r.arg = ($urandom_range(4) == 0) ? $urandom : v;
      if (pick < 50) r.op = fwqt_pkg::OP_WAIT;
      else if (pick < 80) begin
         r.op = fwqt_pkg::OP_WAKE;
         case ($urandom_range(3))
            0: r.arg = $urandom;
            1: r.arg = -$urandom_range(3);
            default: r.arg = $urandom_range(20);
         endcase
      end else if (pick < 87) r.op = fwqt_pkg::OP_WAIT_BITSET;
      else if (pick < 93) begin
         case ($urandom_range(3))
            0: r.op = fwqt_pkg::OP_REQUEUE;
            1: r.op = fwqt_pkg::OP_CMP_REQUEUE;
            2: r.op = fwqt_pkg::OP_WAKE_OP;
            default: r.op = fwqt_pkg::OP_WAKE_BITSET;
         endcase
      end else r.op = 7'($urandom);
      return r;
   endfunction

   // driver: present words at the falling edge, idle in bursts
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            if (drv_gap == 0 && !calm && $urandom_range(5) == 0) drv_gap = $urandom_range(1, 11);
            if (drv_gap > 0 || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (drv_gap > 0) drv_gap--;
            end else begin
               futex_req_type r;
               r = pending_reqs.pop_front();
               req_type <= r.op; req_futex_address <= r.addr; req_word_value <= r.word;
               req_arg_value <= r.arg; req_requester_id <= r.who;
            end
         end else if (!req_valid) begin
            if (drv_gap > 0) drv_gap--;
            else if (pending_reqs.size() > 0) begin
               futex_req_type r;
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_type <= r.op; req_futex_address <= r.addr; req_word_value <= r.word;
               req_arg_value <= r.arg; req_requester_id <= r.who;
            end
         end
         // response stall in bursts
         if (calm) rsp_stall <= 1'b0;
         else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(5) == 0) begin
            rsp_gap = $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // monitor: accepted words at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      req_stall_q <= reset || !(req_valid && !req_stall);
      if (!reset) begin
         if (req_valid && !req_stall) begin
            futex_req_type r;
            r = make_req(req_type, req_futex_address, req_word_value, req_arg_value,
                         req_requester_id);
            if (r.op == fwqt_pkg::OP_WAKE) wakes_sent++;
            expected_rsps.push_back(predict_futex(r));
         end
         if (rsp_valid && !rsp_stall) begin
            futex_rsp_type w;
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               w = expected_rsps.pop_front();
               if (w.status == fwqt_pkg::ST_NOMEM) nomem_seen++;
               if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
               if (rsp_woken_count !== w.woken)
                  report_mismatch("woken_count", rsp_woken_count, w.woken);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i] = '0;
         tbl_count[i] = 0;
      end
      foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every code, queue and table limits
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, '0, 32'sh80000000, 32'sh80000000,
                                      16'hffff));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, '1, 32'sh7fffffff, 32'sh7fffffff,
                                      16'h0000));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, '1, 32'sh7fffffff, 32'sh80000000,
                                      16'h1234));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT_BITSET, '0, 32'sd5, 32'sd5, 16'd1));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT_BITSET, '0, 32'sd5, -32'sd5, 16'd1));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_REQUEUE, '1, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_CMP_REQUEUE, '1, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE_OP, '1, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE_BITSET, '1, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(7'd2, '0, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(7'h7f, '0, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, 48'h5, 32'sd0, 32'sd3, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, '1, 32'sd0, -32'sd1, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, '1, 32'sd0, 32'sd0, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, '1, 32'sd0, 32'sh7fffffff, 16'd0));
      // queue overflow on one address, then wake all
      for (int i = 0; i < NWAIT + 2; i++)
         pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, 48'h77, 32'sd9, 32'sd9, 16'(i)));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, 48'h77, 32'sd0, 32'sd100, 16'd0));
      // fill the table, hit no memory, then drain
      for (int i = 0; i <= NENT; i++)
         pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, 48'h1000 + 48'(i), 32'sd0, 32'sd0,
                                         16'(i)));
      for (int i = 0; i <= NENT; i++)
         pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, 48'h1000 + 48'(i), 32'sd0, 32'sd1,
                                         16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, '0, 32'sd0, 32'sh80000000, 16'd0));
      pending_reqs.push_back(make_req(fwqt_pkg::OP_WAKE, '0, 32'sd0, 32'sd1, 16'd0));

      // random part, last stretch without idling
      for (int i = 0; i < RAND_ITEMS; i++) begin
         pending_reqs.push_back(rand_req());
         if (i % 200 == 199) begin
            for (int k = 0; k < NENT + 1; k++)
               pending_reqs.push_back(make_req(fwqt_pkg::OP_WAIT, 48'({$urandom, $urandom}),
                                               32'sd0, 32'sd0, 16'($urandom)));
         end
      end
      while (pending_reqs.size() > 150) @(posedge clock);
      calm = 1'b1;
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d responses, %0d wakes, %0d table-full results",
               rsp_seen, wakes_sent, nomem_seen);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
